>>> hw/rtl/bgfs_pkg.sv
// ----------------------------------------------------------------------------
// Frame scheduler package
// Shared types, event and result codes for the blank-gated frame scheduler.
// ----------------------------------------------------------------------------
package bgfs_pkg;

    localparam int NUM_SCREENS_DEF = 2;
    localparam int MAX_RESULTS     = 3;

    // Event codes.
    localparam logic [1:0] EV_SCAN_START  = 2'd0;
    localparam logic [1:0] EV_BLANK_START = 2'd1;
    localparam logic [1:0] EV_RENDER_DONE = 2'd2;
    localparam logic [1:0] EV_XFER_DONE   = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_RENDER = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_FREED  = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic       screen;
        logic       slot;
        logic       write_accept;
    } bgfs_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic       screen_index;
        logic       buffer_slot;
    } bgfs_res_t;

    // All results of one event; count is the number of valid entries.
    typedef struct packed {
        logic [1:0]                  count;
        bgfs_res_t [MAX_RESULTS-1:0] res;
    } bgfs_bundle_t;

endpackage

>>> hw/rtl/bgfs_core.sv
// ----------------------------------------------------------------------------
// Frame scheduler core
// Per-screen buffer state and the single-pass event evaluation.
// ----------------------------------------------------------------------------
module bgfs_core #(
    parameter int NUM_SCREENS = bgfs_pkg::NUM_SCREENS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  bgfs_pkg::bgfs_item_t item,
    output bgfs_pkg::bgfs_bundle_t bundle
);

    // Slot registers: bit 1 is the valid bit, bit 0 the slot.
    logic [1:0] render_reg [NUM_SCREENS];
    logic [1:0] ready_reg  [NUM_SCREENS];
    logic [1:0] xfer_reg   [NUM_SCREENS];
    logic       pref_reg   [NUM_SCREENS];
    logic       blank_reg  [NUM_SCREENS];
    logic       want_reg   [NUM_SCREENS];
    logic       busy_reg;

    logic [1:0] render_next [NUM_SCREENS];
    logic [1:0] ready_next  [NUM_SCREENS];
    logic [1:0] xfer_next   [NUM_SCREENS];
    logic       pref_next   [NUM_SCREENS];
    logic       blank_next  [NUM_SCREENS];
    logic       want_next   [NUM_SCREENS];
    logic       busy_next;

    logic       do_write;
    logic       do_render;
    logic       found;
    logic       cand;
    logic [1:0] n;

    function automatic logic holds(input logic [1:0] r, input logic s);
        return r == {1'b1, s};
    endfunction

    always_comb begin
        render_next = render_reg;
        ready_next  = ready_reg;
        xfer_next   = xfer_reg;
        pref_next   = pref_reg;
        blank_next  = blank_reg;
        want_next   = want_reg;
        busy_next   = busy_reg;
        bundle      = '0;
        do_write    = 1'b0;
        do_render   = 1'b0;
        found       = 1'b0;
        cand        = 1'b0;
        n           = 2'd0;

        if (int'(item.screen) < NUM_SCREENS) begin
            for (int i = 0; i < NUM_SCREENS; i++) begin
                if (i == int'(item.screen)) begin
                    case (item.func)
                        bgfs_pkg::EV_SCAN_START: begin
                            blank_next[i] = 1'b0;
                            want_next[i]  = 1'b1;
                            do_render     = 1'b1;
                        end
                        bgfs_pkg::EV_BLANK_START: begin
                            blank_next[i] = 1'b1;
                            do_write      = 1'b1;
                        end
                        bgfs_pkg::EV_RENDER_DONE: begin
                            if (holds(render_next[i], item.slot)) begin
                                render_next[i] = 2'b00;
                            end
                            ready_next[i] = {1'b1, item.slot};
                            do_write      = 1'b1;
                            do_render     = 1'b1;
                        end
                        default: begin
                            if (holds(xfer_next[i], item.slot)) begin
                                xfer_next[i] = 2'b00;
                            end
                            busy_next = 1'b0;
                            bundle.res[n].result_kind  = bgfs_pkg::KIND_FREED;
                            bundle.res[n].screen_index = item.screen;
                            bundle.res[n].buffer_slot  = item.slot;
                            n         = n + 2'd1;
                            do_write  = 1'b1;
                            do_render = 1'b1;
                        end
                    endcase
                end
            end

            // The bus goes to the lowest screen with a ready frame in blanking.
            if (do_write && !busy_next) begin
                for (int i = 0; i < NUM_SCREENS; i++) begin
                    if (!found && ready_next[i][1] && blank_next[i]) begin
                        found = 1'b1;
                        if (item.write_accept) begin
                            busy_next    = 1'b1;
                            xfer_next[i] = {1'b1, ready_next[i][0]};
                            bundle.res[n].result_kind  = bgfs_pkg::KIND_WRITE;
                            bundle.res[n].screen_index = 1'(i);
                            bundle.res[n].buffer_slot  = ready_next[i][0];
                            n             = n + 2'd1;
                            ready_next[i] = 2'b00;
                        end
                    end
                end
            end

            if (do_render) begin
                for (int i = 0; i < NUM_SCREENS; i++) begin
                    if (i == int'(item.screen) && want_next[i] && !render_next[i][1]
                        && !(ready_next[i][1] && xfer_next[i][1])) begin
                        cand = pref_next[i];
                        if (holds(ready_next[i], cand) || holds(xfer_next[i], cand)) begin
                            cand = ~cand;
                        end
                        if (!holds(ready_next[i], cand) && !holds(xfer_next[i], cand)) begin
                            render_next[i] = {1'b1, cand};
                            pref_next[i]   = ~cand;
                            want_next[i]   = 1'b0;
                            bundle.res[n].result_kind  = bgfs_pkg::KIND_RENDER;
                            bundle.res[n].screen_index = item.screen;
                            bundle.res[n].buffer_slot  = cand;
                            n = n + 2'd1;
                        end
                    end
                end
            end
        end
        bundle.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SCREENS; i++) begin
                render_reg[i] <= 2'b00;
                ready_reg[i]  <= 2'b00;
                xfer_reg[i]   <= 2'b00;
                pref_reg[i]   <= 1'b0;
                blank_reg[i]  <= 1'b0;
                want_reg[i]   <= 1'b0;
            end
            busy_reg <= 1'b0;
        end else if (advance) begin
            render_reg <= render_next;
            ready_reg  <= ready_next;
            xfer_reg   <= xfer_next;
            pref_reg   <= pref_next;
            blank_reg  <= blank_next;
            want_reg   <= want_next;
            busy_reg   <= busy_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_set_by_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy_reg) |-> $past(advance && item.write_accept))
        else $error("bus became busy without an accepted write");

    a_state_holds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(busy_reg))
        else $error("bus state changed without an event");
`endif

endmodule

>>> hw/rtl/bgfs_out.sv
// ----------------------------------------------------------------------------
// Frame scheduler result stage
// Holds the results of one event and sends them out one per transaction.
// ----------------------------------------------------------------------------
module bgfs_out (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  bgfs_pkg::bgfs_bundle_t bundle,
    output logic                   load_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [0] screen_index, [1] buffer_slot
    output logic [1:0]             m_tuser,   // [1:0] result_kind
    output logic                   m_tlast
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [1:0]             idx_reg;
    logic [1:0]             idx_next;
    bgfs_pkg::bgfs_bundle_t bundle_reg;
    bgfs_pkg::bgfs_res_t    cur;
    logic                   done;

    assign cur        = bundle_reg.res[idx_reg];
    assign m_tvalid   = valid_reg;
    assign m_tdata    = {6'b0, cur.buffer_slot, cur.screen_index};
    assign m_tuser    = cur.result_kind;
    assign m_tlast    = (idx_reg == bundle_reg.count - 2'd1);
    assign done       = valid_reg && m_tready && m_tlast;
    assign load_ready = !valid_reg || done;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end else if (done) begin
            valid_next = 1'b0;
        end else if (valid_reg && m_tready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bundle_reg <= bundle;
        end
    end

`ifndef NO_ASSERTIONS
    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (idx_reg < bundle_reg.count))
        else $error("result index beyond event result count");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> load_ready)
        else $error("result bundle overwritten before it drained");
`endif

endmodule

>>> hw/rtl/blank_gated_frame_scheduler.sv
// ----------------------------------------------------------------------------
// Blank-gated frame scheduler
// Event-driven render and write scheduling for panels with two buffer slots.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one event (s_tuser) for one screen
// with a slot and a write-accept flag (s_tdata). Each event yields zero to
// three result transactions (render request, write request, buffer freed);
// m_tlast marks the final result of an event, and an event that causes no
// result produces no output transaction.
// Flow: an accepted event waits in the input register, is evaluated
// straight out of it, and its results load the result register once free.
// Further results of the same event follow one per cycle while the
// receiver accepts. Throughput is one event per cycle while each event
// yields at most one result and the receiver keeps up; an event with more
// holds the result register until its last is taken, pacing the input.
// Reset clears all buffer state, flags and the bus-busy bit; no clearing
// pass is needed. When the receiver stalls, the result register holds and
// back-pressure reaches s_tready once the input register is also full.
// ----------------------------------------------------------------------------
module blank_gated_frame_scheduler #(
    parameter int NUM_SCREENS = bgfs_pkg::NUM_SCREENS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] screen, [1] slot, [2] write_accept
    input  logic [1:0] s_tuser,   // [1:0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] screen_index, [1] buffer_slot
    output logic [1:0] m_tuser,   // [1:0] result_kind
    output logic       m_tlast
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    bgfs_pkg::bgfs_item_t   item_reg;
    bgfs_pkg::bgfs_bundle_t bundle;
    logic                   load_ready;
    logic                   advance;
    logic                   s_accept;

    assign advance  = in_valid_reg && load_ready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.func         <= s_tuser;
            item_reg.screen       <= s_tdata[0];
            item_reg.slot         <= s_tdata[1];
            item_reg.write_accept <= s_tdata[2];
        end
    end

    bgfs_core #(
        .NUM_SCREENS(NUM_SCREENS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .advance(advance),
        .item   (item_reg),
        .bundle (bundle)
    );

    bgfs_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && (bundle.count != 2'd0)),
        .bundle    (bundle),
        .load_ready(load_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with an empty input register");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame scheduler testbench
// Drives scan, blank, render-done and transfer-done events into the scheduler,
// predicts the render, write and buffer-freed results of each event from a
// behavioral copy of the per-screen buffer state, and checks every result
// transaction in order. Sender bursts and receiver stalls vary at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_SCREENS = bgfs_pkg::NUM_SCREENS_DEF;
    // No acceptance on either side for this long means the block is stuck.
    // The longest correct quiet stretch is a sender gap plus a receiver hold
    // plus the final drain, well under this limit.
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 64;

    typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SLOW, RX_HOLD} rx_mode_t;

    typedef struct packed {
        bgfs_pkg::bgfs_res_t res;
        logic                last;
    } sched_result_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;   // [0] screen, [1] slot, [2] write_accept
    logic [1:0] s_tuser = 2'd0;   // [1:0] func
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [0] screen_index, [1] buffer_slot
    logic [1:0] m_tuser;          // [1:0] result_kind
    logic       m_tlast;

    // Behavioral copy of the scheduler state. Slot registers hold a valid
    // bit on top and the slot number below it.
    logic [1:0] render_slot [NUM_SCREENS];
    logic [1:0] done_buf    [NUM_SCREENS];
    logic [1:0] sent_buf    [NUM_SCREENS];
    logic       pref_buf    [NUM_SCREENS];
    logic       in_blank    [NUM_SCREENS];
    logic       wants_frame [NUM_SCREENS];
    logic       bus_in_use;

    sched_result_t outstanding_results[$];
    sched_result_t event_results[$];

    int error_count = 0;
    int events_sent = 0;
    int results_checked = 0;
    int kind_seen [3] = '{0, 0, 0};
    int burst_left = 0;
    int quiet_cycles = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int rx_left = 0;

    blank_gated_frame_scheduler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Schedule prediction
    // ------------------------------------------------------------------------
    function automatic bit slot_held(logic [1:0] slot_reg, logic sl);
        return slot_reg[1] && (slot_reg[0] == sl);
    endfunction

    function automatic void add_result(logic [1:0] kind, int s, logic sl);
        sched_result_t r;
        r.res.result_kind = kind;
        r.res.screen_index = s[0];
        r.res.buffer_slot = sl;
        r.last = 1'b0;
        event_results.push_back(r);
    endfunction

    function automatic void start_render(int s);
        logic cand;
        if (!wants_frame[s] || render_slot[s][1])
            return;
        // Both the ready and the transfer buffer are taken: nothing to draw in.
        if (done_buf[s][1] && sent_buf[s][1])
            return;
        cand = pref_buf[s];
        for (int k = 0; k < 2; k++) begin
            if (!slot_held(render_slot[s], cand) && !slot_held(done_buf[s], cand) &&
                !slot_held(sent_buf[s], cand)) begin
                render_slot[s] = {1'b1, cand};
                pref_buf[s] = ~cand;
                wants_frame[s] = 1'b0;
                add_result(bgfs_pkg::KIND_RENDER, s, cand);
                return;
            end
            cand = ~cand;
        end
    endfunction

    function automatic void start_write(logic accept);
        logic sl;
        if (bus_in_use)
            return;
        for (int s = 0; s < NUM_SCREENS; s++) begin
            if (!done_buf[s][1] || !in_blank[s])
                continue;
            // A refused write leaves everything as it was.
            if (!accept)
                return;
            sl = done_buf[s][0];
            bus_in_use = 1'b1;
            done_buf[s] = 2'b00;
            sent_buf[s] = {1'b1, sl};
            add_result(bgfs_pkg::KIND_WRITE, s, sl);
            return;
        end
    endfunction

    function automatic void predict_event(bgfs_pkg::bgfs_item_t ev);
        int s;
        sched_result_t r;
        s = int'(ev.screen);
        event_results.delete();
        if (s >= NUM_SCREENS)
            return;
        case (ev.func)
            bgfs_pkg::EV_SCAN_START: begin
                in_blank[s] = 1'b0;
                wants_frame[s] = 1'b1;
                start_render(s);
            end
            bgfs_pkg::EV_BLANK_START: begin
                in_blank[s] = 1'b1;
                start_write(ev.write_accept);
            end
            bgfs_pkg::EV_RENDER_DONE: begin
                if (slot_held(render_slot[s], ev.slot))
                    render_slot[s] = 2'b00;
                done_buf[s] = {1'b1, ev.slot};
                start_write(ev.write_accept);
                start_render(s);
            end
            default: begin
                // The bus is released and the notice goes out even when no
                // transfer was running on that slot.
                if (slot_held(sent_buf[s], ev.slot))
                    sent_buf[s] = 2'b00;
                bus_in_use = 1'b0;
                add_result(bgfs_pkg::KIND_FREED, s, ev.slot);
                start_write(ev.write_accept);
                start_render(s);
            end
        endcase
        foreach (event_results[i]) begin
            r = event_results[i];
            r.last = (i == event_results.size() - 1);
            outstanding_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Event sender: bursts of random length separated by random gaps.
    // ------------------------------------------------------------------------
    task automatic send_event(logic [1:0] func, logic scr, logic sl, logic accept);
        int gap;
        bgfs_pkg::bgfs_item_t ev;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(10, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
        end
        ev.func = func;
        ev.screen = scr;
        ev.slot = sl;
        ev.write_accept = accept;
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {5'd0, accept, sl, scr};
        do @(posedge aclk); while (!s_tready);
        predict_event(ev);
        burst_left--;
        events_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge aclk) begin
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outstanding_results.size() == 0) begin
                report_mismatch($sformatf("result transaction with no result pending: kind %0d",
                                          m_tuser));
            end else begin
                want = outstanding_results.pop_front();
                results_checked++;
                if (want.res.result_kind <= bgfs_pkg::KIND_FREED)
                    kind_seen[want.res.result_kind]++;
                if (m_tuser !== want.res.result_kind)
                    report_mismatch($sformatf("result_kind: expected %0d, got %0d",
                                              want.res.result_kind, m_tuser));
                if (m_tdata[0] !== want.res.screen_index)
                    report_mismatch($sformatf("screen_index: expected %0d, got %0d",
                                              want.res.screen_index, m_tdata[0]));
                if (m_tdata[1] !== want.res.buffer_slot)
                    report_mismatch($sformatf("buffer_slot: expected %0d, got %0d",
                                              want.res.buffer_slot, m_tdata[1]));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_result: expected %0d, got %0d",
                                              want.last, m_tlast));
            end
        end
    end

    // Receiver back-pressure: open stretches, choppy and slow stretches, and
    // short hard holds.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
            RX_SLOW:   m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] timeout: no transaction for %0d cycles, %0d results pending",
                         $time, QUIET_LIMIT, outstanding_results.size());
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked frame history: stray completions, refused and accepted
    // writes, a busy bus, a render blocked by two held buffers, an event with
    // three results, an overwritten ready frame and a mismatched transfer slot.
    task automatic test_directed_cases();
        send_event(bgfs_pkg::EV_XFER_DONE,   1'b0, 1'b1, 1'b0);
        send_event(bgfs_pkg::EV_RENDER_DONE, 1'b1, 1'b1, 1'b1);
        send_event(bgfs_pkg::EV_SCAN_START,  1'b0, 1'b0, 1'b0);
        send_event(bgfs_pkg::EV_SCAN_START,  1'b1, 1'b1, 1'b1);
        send_event(bgfs_pkg::EV_BLANK_START, 1'b1, 1'b0, 1'b0);
        send_event(bgfs_pkg::EV_BLANK_START, 1'b1, 1'b1, 1'b1);
        send_event(bgfs_pkg::EV_RENDER_DONE, 1'b0, 1'b0, 1'b1);
        send_event(bgfs_pkg::EV_BLANK_START, 1'b0, 1'b0, 1'b1);
        send_event(bgfs_pkg::EV_RENDER_DONE, 1'b1, 1'b0, 1'b1);
        send_event(bgfs_pkg::EV_SCAN_START,  1'b1, 1'b0, 1'b0);
        send_event(bgfs_pkg::EV_SCAN_START,  1'b0, 1'b1, 1'b1);
        send_event(bgfs_pkg::EV_BLANK_START, 1'b0, 1'b0, 1'b1);
        send_event(bgfs_pkg::EV_XFER_DONE,   1'b1, 1'b1, 1'b1);
        send_event(bgfs_pkg::EV_RENDER_DONE, 1'b0, 1'b1, 1'b1);
        send_event(bgfs_pkg::EV_RENDER_DONE, 1'b0, 1'b0, 1'b0);
        send_event(bgfs_pkg::EV_XFER_DONE,   1'b0, 1'b1, 1'b0);
        send_event(bgfs_pkg::EV_XFER_DONE,   1'b0, 1'b0, 1'b1);
        send_event(bgfs_pkg::EV_XFER_DONE,   1'b1, 1'b1, 1'b1);
        send_event(bgfs_pkg::EV_SCAN_START,  1'b1, 1'b1, 1'b1);
        send_event(bgfs_pkg::EV_BLANK_START, 1'b1, 1'b0, 1'b1);
    endtask

    // Mostly well-formed frame traffic: completions name the slot actually
    // being rendered or transferred, so the buffers keep cycling.
    task automatic test_frame_loops(int count);
        logic [1:0] func;
        logic scr;
        logic sl;
        logic accept;
        int pick;
        for (int i = 0; i < count; i++) begin
            scr = 1'($urandom_range(0, NUM_SCREENS - 1));
            sl = 1'($urandom_range(0, 1));
            accept = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                func = bgfs_pkg::EV_SCAN_START;
            end else if (pick < 50) begin
                func = bgfs_pkg::EV_BLANK_START;
            end else if (pick < 78) begin
                func = bgfs_pkg::EV_RENDER_DONE;
                if (render_slot[scr][1] && $urandom_range(0, 9) != 0)
                    sl = render_slot[scr][0];
            end else begin
                func = bgfs_pkg::EV_XFER_DONE;
                if ($urandom_range(0, 9) != 0) begin
                    for (int s = 0; s < NUM_SCREENS; s++) begin
                        if (sent_buf[s][1]) begin
                            scr = s[0];
                            sl = sent_buf[s][0];
                        end
                    end
                end
            end
            send_event(func, scr, sl, accept);
        end
    endtask

    task automatic test_random_events(int count);
        for (int i = 0; i < count; i++)
            send_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        for (int s = 0; s < NUM_SCREENS; s++) begin
            render_slot[s] = 2'b00;
            done_buf[s] = 2'b00;
            sent_buf[s] = 2'b00;
            pref_buf[s] = 1'b0;
            in_blank[s] = 1'b0;
            wants_frame[s] = 1'b0;
        end
        bus_in_use = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_frame_loops(230);
        test_random_events(60);
        s_tvalid <= 1'b0;

        while (outstanding_results.size() != 0)
            @(posedge aclk);
        // Any stray result would show up within this window.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d events; checked %0d results (%0d render, %0d write, %0d freed).",
                 events_sent, results_checked, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("Mismatches found: %0d.", error_count);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
